// ----- src/q4dq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q4dq_pkg: shared types and constants of the Q4 dequantize dot product
// Field widths, fixed-point constants, controller states and the command and
// status structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package q4dq_pkg;

  // Default accumulator width (signed, 30 fraction bits).
  localparam int unsigned AccWidthDef = 48;

  // Input field widths.
  localparam int unsigned ActW   = 16;  // activation, Q3.12
  localparam int unsigned ByteW  = 8;   // packed weight byte
  localparam int unsigned NibW   = 4;   // one weight nibble
  localparam int unsigned ScaleW = 16;  // scale, Q1.14
  localparam int unsigned ZpW    = 10;  // zero point, Q5.4

  // Derived datapath widths.
  localparam int unsigned FracZp = 4;                  // fraction bits of a zero point
  localparam int unsigned DiffW  = NibW + FracZp + 3;  // covers -511..752
  localparam int unsigned WgtW   = ScaleW + DiffW;     // scale * diff, Q.18
  localparam int unsigned TermW  = ActW + WgtW;        // activation * weight, Q.30

  // Zero point used when zero_mode is set: 8.0 in Q5.4.
  localparam logic signed [DiffW-1:0] FixedZp = DiffW'(8 << FracZp);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WEIGHT,
    ST_TERM,
    ST_ACCUM
  } state_e;

  typedef struct packed {
    logic capture;    // register the input beat
    logic weight_en;  // form scale * diff
    logic term_en;    // form activation * weight
    logic accum_en;   // saturating add into the running sum
  } cmd_t;

  typedef struct packed {
    logic last;       // captured beat closes the dot product
  } status_t;

endpackage

// ----- src/q4dq_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q4dq_in_if: input term channel
// Valid/ready channel carrying one activation, packed weight byte and the
// group's dequantization parameters.
// ----------------------------------------------------------------------------
interface q4dq_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [q4dq_pkg::ActW-1:0]      activation;
  logic        [q4dq_pkg::ByteW-1:0]     weight_byte;
  logic                                  high_half;
  logic signed [q4dq_pkg::ScaleW-1:0]    scale;
  logic signed [q4dq_pkg::ZpW-1:0]       zero_point;
  logic                                  last;

  modport source (
    output valid, activation, weight_byte, high_half, scale, zero_point, last,
    input  ready
  );
  modport sink (
    input  valid, activation, weight_byte, high_half, scale, zero_point, last,
    output ready
  );
endinterface

// ----- src/q4dq_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q4dq_out_if: result channel
// Valid/ready channel carrying one finished, saturated dot product.
// ----------------------------------------------------------------------------
interface q4dq_out_if #(
  parameter int unsigned ACC_WIDTH = q4dq_pkg::AccWidthDef
);
  logic                        valid;
  logic                        ready;
  logic signed [ACC_WIDTH-1:0] dot_value;

  modport source (output valid, dot_value, input ready);
  modport sink (input valid, dot_value, output ready);
endinterface

// ----- src/q4dq_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q4dq_cfg_if: configuration write channel
// Valid/ready channel carrying the zero_mode register value.
// ----------------------------------------------------------------------------
interface q4dq_cfg_if;
  logic valid;
  logic ready;
  logic zero_mode;

  modport source (output valid, zero_mode, input ready);
  modport sink (input valid, zero_mode, output ready);
endinterface

// ----- src/q4dq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q4dq_ctrl: sequencing controller
// Walks each term through capture, weight multiply, term multiply and
// accumulate, and owns the result valid flag.
// ----------------------------------------------------------------------------
module q4dq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  input  q4dq_pkg::status_t  status_i,
  output q4dq_pkg::cmd_t     cmd_o
);

  q4dq_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             stall;

  // A closing term waits in the accumulate step while an older result is
  // still held in the output register.
  assign stall = status_i.last && out_valid_q && !out_ready_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      q4dq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = q4dq_pkg::ST_WEIGHT;
        end
      end
      q4dq_pkg::ST_WEIGHT: state_d = q4dq_pkg::ST_TERM;
      q4dq_pkg::ST_TERM:   state_d = q4dq_pkg::ST_ACCUM;
      q4dq_pkg::ST_ACCUM: begin
        if (!stall) begin
          state_d = q4dq_pkg::ST_IDLE;
        end
      end
      default: state_d = q4dq_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      q4dq_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      q4dq_pkg::ST_WEIGHT: cmd_o.weight_en = 1'b1;
      q4dq_pkg::ST_TERM:   cmd_o.term_en   = 1'b1;
      q4dq_pkg::ST_ACCUM:  cmd_o.accum_en  = !stall;
      default: cmd_o = '0;
    endcase
    out_valid_d = (cmd_o.accum_en && status_i.last) || (out_valid_q && !out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= q4dq_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- src/q4dq_dpath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q4dq_dpath: dequantize and accumulate datapath
// Nibble select and zero-point subtract, two registered multiplies, and a
// saturating accumulator with a result register.
// ----------------------------------------------------------------------------
module q4dq_dpath #(
  parameter int unsigned ACC_WIDTH = q4dq_pkg::AccWidthDef
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  q4dq_pkg::cmd_t                       cmd_i,
  output q4dq_pkg::status_t                    status_o,
  input  logic                                 cfg_we_i,
  input  logic                                 cfg_zero_mode_i,
  input  logic signed [q4dq_pkg::ActW-1:0]     activation_i,
  input  logic        [q4dq_pkg::ByteW-1:0]    weight_byte_i,
  input  logic                                 high_half_i,
  input  logic signed [q4dq_pkg::ScaleW-1:0]   scale_i,
  input  logic signed [q4dq_pkg::ZpW-1:0]      zero_point_i,
  input  logic                                 last_i,
  output logic signed [ACC_WIDTH-1:0]          dot_value_o
);

  localparam int unsigned SumW =
      ((ACC_WIDTH > q4dq_pkg::TermW) ? ACC_WIDTH : q4dq_pkg::TermW) + 1;

  localparam logic signed [ACC_WIDTH-1:0] AccMax = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] AccMin = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic                                    zero_mode_q;
  logic signed [q4dq_pkg::ActW-1:0]        act_q;
  logic signed [q4dq_pkg::ScaleW-1:0]      scale_q;
  logic signed [q4dq_pkg::DiffW-1:0]       diff_q, diff_d;
  logic                                    last_q;
  logic signed [q4dq_pkg::WgtW-1:0]        weight_q, weight_d;
  logic signed [q4dq_pkg::TermW-1:0]       term_q, term_d;
  logic signed [ACC_WIDTH-1:0]             acc_q, acc_d;
  logic signed [ACC_WIDTH-1:0]             dot_q;
  logic        [q4dq_pkg::NibW-1:0]        nibble;
  logic signed [q4dq_pkg::DiffW-1:0]       nib_scaled, zp_ext;
  logic signed [SumW-1:0]                  sum;

  // Nibble moved to Q.4 and the zero point subtracted.
  always_comb begin
    nibble     = high_half_i ? weight_byte_i[7:4] : weight_byte_i[3:0];
    nib_scaled = $signed({3'b000, nibble, 4'b0000});
    zp_ext     = zero_mode_q ? q4dq_pkg::FixedZp : q4dq_pkg::DiffW'(zero_point_i);
    diff_d     = nib_scaled - zp_ext;
  end

  assign weight_d = q4dq_pkg::WgtW'(scale_q) * q4dq_pkg::WgtW'(diff_q);
  assign term_d   = q4dq_pkg::TermW'(act_q) * q4dq_pkg::TermW'(weight_q);

  // Exact sum in a wider word, then clamped to the accumulator range.
  always_comb begin
    sum = SumW'(acc_q) + SumW'(term_q);
    if (sum > SumW'(AccMax)) begin
      acc_d = AccMax;
    end else if (sum < SumW'(AccMin)) begin
      acc_d = AccMin;
    end else begin
      acc_d = ACC_WIDTH'(sum);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zero_mode_q <= 1'b0;
      acc_q       <= '0;
      last_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        zero_mode_q <= cfg_zero_mode_i;
      end
      if (cmd_i.capture) begin
        last_q <= last_i;
      end
      if (cmd_i.accum_en) begin
        acc_q <= last_q ? '0 : acc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      act_q   <= activation_i;
      scale_q <= scale_i;
      diff_q  <= diff_d;
    end
    if (cmd_i.weight_en) begin
      weight_q <= weight_d;
    end
    if (cmd_i.term_en) begin
      term_q <= term_d;
    end
    if (cmd_i.accum_en && last_q) begin
      dot_q <= acc_d;
    end
  end

  assign status_o.last = last_q;
  assign dot_value_o   = dot_q;

endmodule

// ----- src/q4_dequant_dot_product.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q4_dequant_dot_product: 4-bit weight dequantize and dot product engine
// Accumulates activation * scale * (nibble - zero) per term and delivers the
// saturated sum on the term marked last.
// ----------------------------------------------------------------------------
// Result timing: out_o.valid is registered and rises as a closing term leaves the
//   accumulate step, after its capture, weight and term multiply steps; a stall there delays it.
// Pacing: a new term is taken only after the previous one has passed the four
//   controller steps (capture, weight multiply, term multiply, accumulate); a
//   closing term waits in the accumulate step while the previous result is not yet taken.
// Reset (rst_ni, asynchronous, active low) clears the controller, the result
//   valid flag, the running sum and zero_mode; no clearing pass is needed.
// ----------------------------------------------------------------------------
module q4_dequant_dot_product #(
  parameter int unsigned ACC_WIDTH = q4dq_pkg::AccWidthDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  q4dq_cfg_if.sink      cfg_i,
  q4dq_in_if.sink       in_i,
  q4dq_out_if.source    out_o
);

  q4dq_pkg::cmd_t    cmd;
  q4dq_pkg::status_t status;

  // The single configuration register is always writable. The user is to make writes only
  // while the engine is idle, so no term sees a change mid-flight; the block does not enforce this.
  assign cfg_i.ready = 1'b1;

  // The controller sequences each beat through the datapath one step per cycle unless a
  // closing term stalls in its accumulate step, and holds the result valid flag for the output register.
  q4dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath captures the beat with the nibble already turned into a
  // Q.4 difference, multiplies by scale (Q.18) and by activation (Q.30),
  // and adds into the saturating accumulator. The result register is kept
  // apart from the accumulator so a new dot product can start while the
  // previous result waits to be taken.
  q4dq_dpath #(
    .ACC_WIDTH (ACC_WIDTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .cfg_we_i        (cfg_i.valid),
    .cfg_zero_mode_i (cfg_i.zero_mode),
    .activation_i    (in_i.activation),
    .weight_byte_i   (in_i.weight_byte),
    .high_half_i     (in_i.high_half),
    .scale_i         (in_i.scale),
    .zero_point_i    (in_i.zero_point),
    .last_i          (in_i.last),
    .dot_value_o     (out_o.dot_value)
  );

endmodule

// ----- src/q4dq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q4dq_checker: port-level checks of the dot product engine
// Watches the handshakes on the top-level ports and is bound to the top level.
// ----------------------------------------------------------------------------
module q4dq_checker #(
  parameter int unsigned ACC_WIDTH = q4dq_pkg::AccWidthDef
) (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_i,
  input logic                  out_valid_i,
  input logic                  out_ready_i,
  input logic [ACC_WIDTH-1:0]  dot_value_i,
  input logic                  cfg_ready_i
);

  logic in_beat;
  assign in_beat = in_valid_i && in_ready_i;

  // A held result keeps its value until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(dot_value_i))
    else $error("result changed or dropped while stalled");

  // One term at a time: the input closes right after a beat.
  a_in_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat |=> !in_ready_i)
    else $error("input accepted a beat while a term was in flight");

  // A new result appears only as the engine leaves its accumulate step, so
  // the input has just reopened after being closed.
  a_out_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> in_ready_i && $past(!in_ready_i))
    else $error("result appeared without a finished closing term");

  // The configuration register never stalls a write.
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration write stalled");

endmodule

bind q4_dequant_dot_product q4dq_checker #(
  .ACC_WIDTH (ACC_WIDTH)
) u_q4dq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .dot_value_i (out_o.dot_value),
  .cfg_ready_i (cfg_i.ready)
);

// ----- bench/q4dq_dot_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// q4dq_dot_checker: result predictor and scoreboard for the Q4 dot product
// Watches the configuration, term and result channels, keeps its own running
// sum and zero_mode copy, and compares every result beat with the oldest
// predicted dot product.
// ----------------------------------------------------------------------------
module q4dq_dot_checker #(
  parameter int unsigned ACC_WIDTH = q4dq_pkg::AccWidthDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  q4dq_cfg_if  cfg_mon,
  q4dq_in_if   term_mon,
  q4dq_out_if  dot_mon,
  output int   fail_count_o,
  output int   pending_o
);

  typedef logic signed [ACC_WIDTH-1:0] dot_t;

  localparam longint SumMax = longint'((64'd1 << (ACC_WIDTH - 1)) - 64'd1);
  localparam longint SumMin = -SumMax - 1;
  localparam longint ZeroModeQ4 = longint'(8) << q4dq_pkg::FracZp;

  logic   zero_mode_q;
  longint dot_sum;
  dot_t   expected_dots[$];

  // One term of the dot product: activation * scale * (nibble - zero), Q.30.
  function automatic longint dequant_term(
    logic signed [q4dq_pkg::ActW-1:0]   act,
    logic        [q4dq_pkg::ByteW-1:0]  wbyte,
    logic                               high_half,
    logic signed [q4dq_pkg::ScaleW-1:0] scl,
    logic signed [q4dq_pkg::ZpW-1:0]    zp,
    logic                               zero_mode
  );
    logic [q4dq_pkg::NibW-1:0] nib;
    longint                    zero_q4;
    longint                    diff;
    nib     = high_half ? wbyte[2*q4dq_pkg::NibW-1:q4dq_pkg::NibW]
                        : wbyte[q4dq_pkg::NibW-1:0];
    zero_q4 = zero_mode ? ZeroModeQ4 : longint'(zp);
    diff    = (longint'(nib) << q4dq_pkg::FracZp) - zero_q4;
    return longint'(act) * longint'(scl) * diff;
  endfunction

  // Adds a term and clamps to the signed accumulator range.
  function automatic longint sat_accumulate(longint acc, longint t);
    if (t > 0 && acc > SumMax - t) return SumMax;
    if (t < 0 && acc < SumMin - t) return SumMin;
    return acc + t;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    dot_t got_dot;
    dot_t want_dot;
    if (!rst_ni) begin
      zero_mode_q = 1'b0;
      dot_sum     = 0;
      expected_dots.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        zero_mode_q = cfg_mon.zero_mode;
      end
      if (term_mon.valid && term_mon.ready) begin
        dot_sum = sat_accumulate(dot_sum,
                                 dequant_term(term_mon.activation, term_mon.weight_byte,
                                              term_mon.high_half, term_mon.scale,
                                              term_mon.zero_point, zero_mode_q));
        if (term_mon.last) begin
          expected_dots.push_back(dot_t'(dot_sum));
          dot_sum = 0;
        end
      end
      if (dot_mon.valid && dot_mon.ready) begin
        got_dot = dot_mon.dot_value;
        if (expected_dots.size() == 0) begin
          fail_count_o++;
          $display("%0t: unexpected dot product beat, expected none actual %0d",
                   $realtime, got_dot);
        end else begin
          want_dot = expected_dots.pop_front();
          if (got_dot !== want_dot) begin
            fail_count_o++;
            $display("%0t: dot_value mismatch, expected %0d actual %0d",
                     $realtime, want_dot, got_dot);
          end
        end
      end
      pending_o = expected_dots.size();
    end
  end

endmodule

// ----- bench/tb_q4_dequant_dot_product.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_q4_dequant_dot_product: testbench of the Q4 dequantize dot product
// Drives directed and random dot products through the term channel under
// bursty input and a stalling result receiver, switches zero_mode between
// phases, and lets the checker module predict and compare every result.
// ----------------------------------------------------------------------------
module tb_q4_dequant_dot_product;

  localparam int unsigned AccW = q4dq_pkg::AccWidthDef;
  localparam int ClkPeriod = 8;
  localparam int ResetCycles = 6;
  // Cycles allowed after the last expected result for terms that never produce
  // one (non-closing terms still walk through the four controller steps).
  localparam int SettleCycles = 8;
  // About five hundred terms fit well inside this limit.
  localparam int CycleLimit = 200000;
  localparam int RandomTermsPerPhase = 30;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending_dots;
  int   cycle_count;
  int   burst_left;

  q4dq_cfg_if                     cfg_bus ();
  q4dq_in_if                      term_bus ();
  q4dq_out_if #(.ACC_WIDTH(AccW)) dot_bus ();

  q4_dequant_dot_product #(.ACC_WIDTH(AccW)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (term_bus),
    .out_o  (dot_bus)
  );

  q4dq_dot_checker #(.ACC_WIDTH(AccW)) checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_mon      (cfg_bus),
    .term_mon     (term_bus),
    .dot_mon      (dot_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending_dots)
  );

  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Watchdog: a hung handshake or a missing result ends the run here.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("q4_dequant_dot_product verification failed");
      $finish;
    end
  end

  // The result receiver stalls on a pattern of its own. It switches between
  // long always-ready stretches, coin-flip readiness, and blocks of stall
  // cycles so that back pressure lands on closing terms in the accumulate step.
  initial begin
    int mode;
    int span;
    dot_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      mode = $urandom_range(2, 0);
      span = $urandom_range(60, 20);
      for (int i = 0; i < span; i++) begin
        @(negedge clk_i);
        case (mode)
          0: begin
            dot_bus.ready <= 1'b1;
          end
          1: begin
            dot_bus.ready <= 1'($urandom_range(1, 0));
          end
          default: begin
            dot_bus.ready <= ((i % 10) >= 7);
          end
        endcase
      end
    end
  end

  // Writes zero_mode. Called at a falling edge while the block is idle, and
  // returns at the falling edge after the write beat.
  task automatic write_zero_mode(input logic mode);
    cfg_bus.valid     <= 1'b1;
    cfg_bus.zero_mode <= mode;
    do @(posedge clk_i); while (!cfg_bus.ready);
    @(negedge clk_i);
    cfg_bus.valid <= 1'b0;
  endtask

  // Sender pacing: terms go out in bursts of random length. Between bursts the
  // valid line drops for a random gap, and about a third of the bursts follow
  // their predecessor with no gap at all.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(5, 1);
      if (gap > 0) begin
        term_bus.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(16, 1);
    end
    burst_left--;
  endtask

  // Presents one term beat at a falling edge and holds it until accepted.
  // Valid is left high so the next beat of a burst follows without a bubble.
  task automatic send_term(
    input logic signed [q4dq_pkg::ActW-1:0]   act,
    input logic        [q4dq_pkg::ByteW-1:0]  wbyte,
    input logic                               high_half,
    input logic signed [q4dq_pkg::ScaleW-1:0] scl,
    input logic signed [q4dq_pkg::ZpW-1:0]    zp,
    input logic                               last
  );
    pace_sender();
    term_bus.valid       <= 1'b1;
    term_bus.activation  <= act;
    term_bus.weight_byte <= wbyte;
    term_bus.high_half   <= high_half;
    term_bus.scale       <= scl;
    term_bus.zero_point  <= zp;
    term_bus.last        <= last;
    do @(posedge clk_i); while (!term_bus.ready);
    @(negedge clk_i);
  endtask

  // Activations and scales lean toward their corner values now and then so
  // that the largest products show up in the random part too.
  function automatic logic [15:0] pick_q16();
    case ($urandom_range(11, 0))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random_term(input logic last);
    send_term(pick_q16(), 8'($urandom), 1'($urandom), pick_q16(), 10'($urandom), last);
  endtask

  // Random dot products: mostly short ones, a few single-term ones, and now
  // and then a longer one of up to 24 terms.
  task automatic run_random_dots(input int num_terms);
    int sent;
    int len;
    sent = 0;
    while (sent < num_terms) begin
      case ($urandom_range(7, 0))
        0:       len = 1;
        1:       len = $urandom_range(24, 13);
        default: len = $urandom_range(12, 2);
      endcase
      for (int k = 0; k < len; k++) begin
        send_random_term(k == len - 1);
      end
      sent += len;
    end
  endtask

  // Drives the accumulator into its clamp with full-size terms of one sign
  // (activation -8.0 times scale +-2.0 times a nibble of 15 against zero
  // point -32.0), then adds a few random terms to the clamped value before
  // closing. Needs zero_mode 0: with the fixed zero point the terms are small.
  task automatic run_saturating_dot(input logic positive);
    int len;
    len = $urandom_range(200, 180);
    for (int k = 0; k < len; k++) begin
      send_term(16'sh8000, 8'hFF, 1'($urandom), positive ? 16'sh8000 : 16'sh7FFF,
                10'sh200, 1'b0);
    end
    for (int k = 0; k < 3; k++) begin
      send_random_term(k == 2);
    end
  endtask

  // Waits until every predicted result has arrived and the block has had time
  // to finish any non-closing term still in flight.
  task automatic settle();
    term_bus.valid <= 1'b0;
    burst_left = 0;
    while (pending_dots != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  initial begin
    burst_left           = 0;
    rst_ni               = 1'b0;
    cfg_bus.valid        = 1'b0;
    cfg_bus.zero_mode    = 1'b0;
    term_bus.valid       = 1'b0;
    term_bus.activation  = '0;
    term_bus.weight_byte = '0;
    term_bus.high_half   = 1'b0;
    term_bus.scale       = '0;
    term_bus.zero_point  = '0;
    term_bus.last        = 1'b0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed part, zero_mode still at its reset value 0.
    // Near-largest positive single term: 32767 * 32767 * (15.0 - (-32.0)).
    send_term(16'sh7FFF, 8'hF0, 1'b1, 16'sh7FFF, 10'sh200, 1'b1);
    // Corner negative operands on the low nibble: (-8.0) * (-2.0) * 47.0.
    send_term(16'sh8000, 8'h0F, 1'b0, 16'sh8000, 10'sh200, 1'b1);
    // Most negative difference: nibble 0 against zero point +31.9375.
    send_term(16'sh8000, 8'h00, 1'b0, 16'sh7FFF, 10'sh1FF, 1'b1);
    // Zero activation, zero scale and a zero difference each kill the term.
    send_term(16'sh0000, 8'hFF, 1'b1, 16'sh7FFF, 10'sh000, 1'b1);
    send_term(16'sh7FFF, 8'hFF, 1'b0, 16'sh0000, 10'sh1FF, 1'b1);
    send_term(16'sh1000, 8'h5A, 1'b1, 16'sh4000, 10'sh050, 1'b1);
    // Both nibbles of one byte, 1.0 * 1.0 each, in a two-term product.
    send_term(16'sh1000, 8'hA5, 1'b0, 16'sh4000, 10'sh000, 1'b0);
    send_term(16'sh1000, 8'hA5, 1'b1, 16'sh4000, 10'sh000, 1'b1);
    // All-ones operands: -1 LSB activation, scale and zero point, nibble 15.
    send_term(16'shFFFF, 8'hFF, 1'b1, 16'shFFFF, 10'sh3FF, 1'b1);
    // Mixed-sign operands in three terms that all come out negative and add up.
    send_term(16'sh7FFF, 8'h3C, 1'b1, 16'sh2000, 10'sh080, 1'b0);
    send_term(16'sh8000, 8'h3C, 1'b0, 16'sh2000, 10'sh080, 1'b0);
    send_term(16'sh0001, 8'h81, 1'b1, 16'sh8001, 10'sh201, 1'b1);
    settle();

    // zero_mode 1: the zero point field must be ignored, so very different
    // zero points give the same weight.
    write_zero_mode(1'b1);
    send_term(16'sh7FFF, 8'hF0, 1'b1, 16'sh7FFF, 10'sh200, 1'b1);
    send_term(16'sh7FFF, 8'hF0, 1'b1, 16'sh7FFF, 10'sh1FF, 1'b1);
    send_term(16'sh8000, 8'h08, 1'b0, 16'sh8000, 10'sh3FF, 1'b0);
    send_term(16'sh8000, 8'h00, 1'b1, 16'sh8000, 10'sh155, 1'b1);
    run_random_dots(RandomTermsPerPhase);
    settle();

    // zero_mode 0 with a run into the positive clamp.
    write_zero_mode(1'b0);
    run_random_dots(RandomTermsPerPhase / 2);
    run_saturating_dot(1'b1);
    run_random_dots(RandomTermsPerPhase / 2);
    settle();

    write_zero_mode(1'b1);
    run_random_dots(RandomTermsPerPhase);
    settle();

    // zero_mode 0 again with a run into the negative clamp.
    write_zero_mode(1'b0);
    run_random_dots(RandomTermsPerPhase / 2);
    run_saturating_dot(1'b0);
    run_random_dots(RandomTermsPerPhase / 2);
    settle();

    if (fail_count == 0) begin
      $display("q4_dequant_dot_product verification clean");
    end else begin
      $display("q4_dequant_dot_product verification failed");
    end
    $finish;
  end

endmodule
